// ===== hw/rtl/tii_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tii_pkg: shared types for the triangle incenter inset block
// Word types for the input and output channels and the status codes.
// ----------------------------------------------------------------------------
package tii_pkg;

	localparam int CW = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_FRAC  = 2'd1,
		ST_DEGEN     = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by_coord;
		logic signed [CW-1:0] bz;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
	} tri_in_t;

	typedef struct packed {
		logic signed [CW-1:0] new_ax;
		logic signed [CW-1:0] new_ay;
		logic signed [CW-1:0] new_az;
		logic signed [CW-1:0] new_bx;
		logic signed [CW-1:0] new_by;
		logic signed [CW-1:0] new_bz;
		logic signed [CW-1:0] new_cx;
		logic signed [CW-1:0] new_cy;
		logic signed [CW-1:0] new_cz;
		logic [1:0]           status;
	} tri_out_t;

endpackage

// ===== hw/rtl/triangle_incenter_inset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_incenter_inset: moves triangle corners toward the incenter
// Side lengths by pipelined root, incenter by pipelined divide, then a
// per-corner step of fraction t toward it.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | word
//  in       | in        | in_valid/in_stall   | tri_in_t
//  out      | out       | out_valid/out_stall | tri_out_t
//  cfg      | in        | cfg_we              | inset_fraction, 16 bits
//
//  One triangle per cycle while the output is not stalled; the root and
//  divide pipelines produce one result bit per stage.
//  Reset clears valid bits and sets the fraction to one half.
//  A stall freezes the whole pipeline; in_stall follows a full, stalled output stage.
// ----------------------------------------------------------------------------
module triangle_incenter_inset (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tii_pkg::tri_in_t    in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output tii_pkg::tri_out_t   out_word,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);
	import tii_pkg::*;

	localparam int W   = CW;
	localparam int DWD = W + 1;           // difference width
	localparam int RW  = W + 2;           // root width (sqrt of 3*(2^W)^2)
	localparam int PW  = RW + 2;          // perimeter width
	localparam int MW  = RW + W + 2;      // weighted-sum magnitude width
	localparam int SQL = RW;              // sqrt latency
	localparam int DVL = MW + 1;          // divider latency
	localparam int LAT = 3 + SQL + 1 + DVL + 4;

	logic [15:0] frac_q;
	logic        en;
	logic [LAT-1:0] vld_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= 16'h8000;
			vld_q  <= '0;
		end else begin
			if (cfg_we) frac_q <= cfg_data;
			if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// corners v[corner][axis], taken as signed W-bit values
	logic signed [W-1:0] v_in [3][3];
	assign v_in[0][0] = W'(in_word.ax);
	assign v_in[0][1] = W'(in_word.ay);
	assign v_in[0][2] = W'(in_word.az);
	assign v_in[1][0] = W'(in_word.bx);
	assign v_in[1][1] = W'(in_word.by_coord);
	assign v_in[1][2] = W'(in_word.bz);
	assign v_in[2][0] = W'(in_word.cx);
	assign v_in[2][1] = W'(in_word.cy);
	assign v_in[2][2] = W'(in_word.cz);

	// corners travel down a delay line for the final step
	localparam int VB = 9 * W;
	logic [VB-1:0] vdl [LAT-1];
	logic [VB-1:0] vflat;
	for (genvar i = 0; i < 3; i++) begin : g_fl
		for (genvar j = 0; j < 3; j++) begin : g_fa
			assign vflat[(i*3+j)*W +: W] = v_in[i][j];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			vdl[0] <= vflat;
			for (int s = 1; s < LAT - 1; s++) vdl[s] <= vdl[s-1];
		end
	end

	// s1: magnitudes of differences; s2: squares; s3: sum
	logic [DWD-1:0]  d_s1  [3][3];
	logic [2*DWD-1:0] sq_s2 [3][3];
	logic [2*RW-1:0] ss_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				for (int j = 0; j < 3; j++) begin
					logic signed [DWD-1:0] df;
					df = DWD'(v_in[(e+1)%3][j]) - DWD'(v_in[(e+2)%3][j]);
					d_s1[e][j] <= df[DWD-1] ? DWD'(-df) : DWD'(df);
				end
			end
			for (int e = 0; e < 3; e++)
				for (int j = 0; j < 3; j++)
					sq_s2[e][j] <= d_s1[e][j] * d_s1[e][j];
			for (int e = 0; e < 3; e++)
				ss_s3[e] <= (2*RW)'(sq_s2[e][0]) + (2*RW)'(sq_s2[e][1])
					+ (2*RW)'(sq_s2[e][2]);
		end
	end

	logic [RW-1:0] len [3];
	for (genvar e = 0; e < 3; e++) begin : g_sq
		tii_sqrt_pipe #(.RW(RW)) u_sqrt (
			.clk(clk), .en(en), .radicand(ss_s3[e]), .root(len[e])
		);
	end

	// weighted sums per axis; corner positions at this point
	localparam int PS = 3 + SQL;
	logic signed [W-1:0] vp [3][3];
	for (genvar i = 0; i < 3; i++) begin : g_vp
		for (genvar j = 0; j < 3; j++) begin : g_vpa
			assign vp[i][j] = vdl[PS-1][(i*3+j)*W +: W];
		end
	end

	// one stage: products and perimeter (products are up to RW x W)
	logic signed [MW:0]  prod_s4 [3][3];
	logic [PW-1:0]       per_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s4[i][j] <= $signed({1'b0, len[i]}) * (MW+1)'(vp[i][j]);
			per_s4 <= PW'(len[0]) + PW'(len[1]) + PW'(len[2]);
		end
	end

	logic [MW-1:0] mag_n [3];
	logic [2:0]    neg_n;
	for (genvar j = 0; j < 3; j++) begin : g_ws
		logic signed [MW+1:0] sum;
		assign sum = (MW+2)'(prod_s4[0][j]) + (MW+2)'(prod_s4[1][j])
			+ (MW+2)'(prod_s4[2][j]);
		assign neg_n[j] = sum[MW+1];
		assign mag_n[j] = sum[MW+1] ? MW'(-sum) : MW'(sum);
	end

	logic [MW-1:0] quo [3];
	logic [2:0]    negd;
	logic [2:0]    zerod;
	for (genvar j = 0; j < 3; j++) begin : g_dv
		logic [PW-1:0] den;
		assign den = (per_s4 == '0) ? PW'(1) : per_s4;
		tii_div_pipe #(.NW(MW), .DW(PW), .SW(2)) u_div (
			.clk(clk), .en(en), .num(mag_n[j]), .den(den),
			.side_in({neg_n[j], per_s4 == '0}),
			.side_out({negd[j], zerod[j]}), .quo(quo[j])
		);
	end

	// incenter, then differences, then scaled step, then output
	localparam int QS = PS + 1 + DVL;
	logic signed [W-1:0]  inc_s5 [3];
	logic                 zero_s5;
	logic signed [W:0]    dd_s6  [3][3];
	logic                 zero_s6;
	logic [W+16:0]        stp_s7 [3][3];
	logic                 dn_s7  [3][3];
	logic                 zero_s7;
	logic [15:0]          t_s6;
	logic signed [W-1:0]  vq [3][3];
	for (genvar i = 0; i < 3; i++) begin : g_vq
		for (genvar j = 0; j < 3; j++) begin : g_vqa
			assign vq[i][j] = vdl[QS][(i*3+j)*W +: W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				inc_s5[j] <= negd[j] ? W'(-quo[j]) : W'(quo[j]);
			// all three lanes carry the same zero-perimeter flag
			zero_s5 <= &zerod;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					dd_s6[i][j] <= (W+1)'(inc_s5[j]) - (W+1)'(vq[i][j]);
			zero_s6 <= zero_s5;
			t_s6    <= frac_q;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					logic [W:0] m;
					m = dd_s6[i][j][W] ? (W+1)'(-dd_s6[i][j]) : (W+1)'(dd_s6[i][j]);
					stp_s7[i][j] <= (W+17)'(m) * (W+17)'(t_s6) + (W+17)'(16'h8000);
					dn_s7[i][j]  <= dd_s6[i][j][W];
				end
			zero_s7 <= zero_s6;
		end
	end

	tri_out_t res_n;
	logic [1:0] st_n;
	logic signed [W-1:0] vo [3][3];
	logic signed [W-1:0] r [3][3];
	for (genvar i = 0; i < 3; i++) begin : g_r
		for (genvar j = 0; j < 3; j++) begin : g_ra
			logic [W:0] s;
			assign vo[i][j] = vdl[QS+2][(i*3+j)*W +: W];
			assign s = stp_s7[i][j][W+16:16];
			assign r[i][j] = (st_n != ST_OK) ? vo[i][j] :
				dn_s7[i][j] ? W'(vo[i][j] - s) : W'(vo[i][j] + s);
		end
	end
	// t is sampled at s6 time; the user must change config only while idle, the block does not enforce it
	assign st_n = (t_s6 == '0) ? ST_BAD_FRAC : zero_s7 ? ST_DEGEN : ST_OK;
	always_comb begin
		res_n = '0;
		res_n.new_ax = CW'(r[0][0]);
		res_n.new_ay = CW'(r[0][1]);
		res_n.new_az = CW'(r[0][2]);
		res_n.new_bx = CW'(r[1][0]);
		res_n.new_by = CW'(r[1][1]);
		res_n.new_bz = CW'(r[1][2]);
		res_n.new_cx = CW'(r[2][0]);
		res_n.new_cy = CW'(r[2][1]);
		res_n.new_cz = CW'(r[2][2]);
		res_n.status = st_n;
	end
	always_ff @(posedge clk) begin
		if (en) out_word <= res_n;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word lost under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to output stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status != 2'd3)
		else $error("bad status code");
endmodule

// ===== hw/rtl/tii_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tii_sqrt_pipe: pipelined floor square root
// Restoring root, one result bit per stage; input 2*RW bits, root RW bits.
// ----------------------------------------------------------------------------
module tii_sqrt_pipe #(
	parameter int RW = 34
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] radicand,
	output logic [RW-1:0]   root
);
	logic [RW-1:0]   r_s   [RW+1];
	logic [2*RW-1:0] rem_s [RW+1];

	assign r_s[0]   = '0;
	assign rem_s[0] = radicand;

	for (genvar k = 0; k < RW; k++) begin : g_bit
		localparam int B = RW - 1 - k;
		logic [2*RW+1:0] trial;
		logic [RW-1:0]   r_q;
		logic [2*RW-1:0] rem_q;
		// (2r + 2^B)*2^B compared against remaining radicand
		assign trial = ({2'b0, {RW{1'b0}}, r_s[k]} << (B + 1))
			+ ({{(2*RW+1){1'b0}}, 1'b1} << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial <= {2'b0, rem_s[k]}) begin
					r_q   <= r_s[k] | (RW'(1) << B);
					rem_q <= rem_s[k] - trial[2*RW-1:0];
				end else begin
					r_q   <= r_s[k];
					rem_q <= rem_s[k];
				end
			end
		end
		assign r_s[k+1]   = r_q;
		assign rem_s[k+1] = rem_q;
	end

	assign root = r_s[RW];
endmodule

// ===== hw/rtl/tii_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tii_div_pipe: pipelined rounding divider
// Restoring divide, one quotient bit per stage, then round half up.
// Side data rides along and appears with the quotient.
// ----------------------------------------------------------------------------
module tii_div_pipe #(
	parameter int NW = 68,
	parameter int DW = 35,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [NW-1:0] q_s   [NW+1];
	logic [DW:0]   rem_s [NW+1];
	logic [NW-1:0] n_s   [NW+1];
	logic [DW-1:0] d_s   [NW+1];
	logic [SW-1:0] x_s   [NW+1];

	assign q_s[0]   = '0;
	assign rem_s[0] = '0;
	assign n_s[0]   = num;
	assign d_s[0]   = den;
	assign x_s[0]   = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_bit
		logic [DW+1:0] sh;
		logic [NW-1:0] q_q, n_q;
		logic [DW:0]   rem_q;
		logic [DW-1:0] d_q;
		logic [SW-1:0] x_q;
		assign sh = {rem_s[k], n_s[k][NW-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_q <= n_s[k] << 1;
				d_q <= d_s[k];
				x_q <= x_s[k];
				if (sh >= {2'b0, d_s[k]}) begin
					rem_q <= (DW+1)'(sh - {2'b0, d_s[k]});
					q_q   <= {q_s[k][NW-2:0], 1'b1};
				end else begin
					rem_q <= sh[DW:0];
					q_q   <= {q_s[k][NW-2:0], 1'b0};
				end
			end
		end
		assign q_s[k+1]   = q_q;
		assign rem_s[k+1] = rem_q;
		assign n_s[k+1]   = n_q;
		assign d_s[k+1]   = d_q;
		assign x_s[k+1]   = x_q;
	end

	// rem >= d - rem  <=>  2*rem >= d
	always_ff @(posedge clk) begin
		if (en) begin
			quo      <= q_s[NW] + NW'({rem_s[NW], 1'b0} >= {2'b0, d_s[NW]});
			side_out <= x_s[NW];
		end
	end
endmodule
